// ===== hdl/eight_bit_cpu_alu_with_flags_core_assert.svh =====
// Assertion macros shared by the register file and ALU block.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_ASSERT_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define EBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define EBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ebc_alu_pkg.sv =====
// Types, codes and decode helpers of the register file and ALU block.
package ebc_alu_pkg;

    localparam int ACT_W  = 5;
    localparam int TGT_W  = 4;
    localparam int BPOS_W = 3;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int ROWS   = 4;
    localparam int ROW_W  = $clog2(ROWS);

    // Operation codes.
    localparam logic [ACT_W-1:0] ACT_ADD   = 5'd0;
    localparam logic [ACT_W-1:0] ACT_ADDHL = 5'd1;
    localparam logic [ACT_W-1:0] ACT_ADC   = 5'd2;
    localparam logic [ACT_W-1:0] ACT_SUB   = 5'd3;
    localparam logic [ACT_W-1:0] ACT_SBC   = 5'd4;
    localparam logic [ACT_W-1:0] ACT_AND   = 5'd5;
    localparam logic [ACT_W-1:0] ACT_OR    = 5'd6;
    localparam logic [ACT_W-1:0] ACT_XOR   = 5'd7;
    localparam logic [ACT_W-1:0] ACT_CP    = 5'd8;
    localparam logic [ACT_W-1:0] ACT_INC   = 5'd9;
    localparam logic [ACT_W-1:0] ACT_DEC   = 5'd10;
    localparam logic [ACT_W-1:0] ACT_CCF   = 5'd11;
    localparam logic [ACT_W-1:0] ACT_SCF   = 5'd12;
    localparam logic [ACT_W-1:0] ACT_RRA   = 5'd13;
    localparam logic [ACT_W-1:0] ACT_RLA   = 5'd14;
    localparam logic [ACT_W-1:0] ACT_RRCA  = 5'd15;
    localparam logic [ACT_W-1:0] ACT_RLCA  = 5'd16;
    localparam logic [ACT_W-1:0] ACT_CPL   = 5'd17;
    localparam logic [ACT_W-1:0] ACT_BIT   = 5'd18;
    localparam logic [ACT_W-1:0] ACT_RES   = 5'd19;
    localparam logic [ACT_W-1:0] ACT_SET   = 5'd20;
    localparam logic [ACT_W-1:0] ACT_SRL   = 5'd21;
    localparam logic [ACT_W-1:0] ACT_RR    = 5'd22;
    localparam logic [ACT_W-1:0] ACT_RL    = 5'd23;
    localparam logic [ACT_W-1:0] ACT_RRC   = 5'd24;
    localparam logic [ACT_W-1:0] ACT_RLC   = 5'd25;
    localparam logic [ACT_W-1:0] ACT_SRA   = 5'd26;
    localparam logic [ACT_W-1:0] ACT_SLA   = 5'd27;
    localparam logic [ACT_W-1:0] ACT_SWAP  = 5'd28;
    localparam logic [ACT_W-1:0] ACT_LDI   = 5'd29;

    // Operand codes.
    localparam logic [TGT_W-1:0] TGT_A  = 4'd0;
    localparam logic [TGT_W-1:0] TGT_B  = 4'd1;
    localparam logic [TGT_W-1:0] TGT_C  = 4'd2;
    localparam logic [TGT_W-1:0] TGT_D  = 4'd3;
    localparam logic [TGT_W-1:0] TGT_E  = 4'd4;
    localparam logic [TGT_W-1:0] TGT_H  = 4'd5;
    localparam logic [TGT_W-1:0] TGT_L  = 4'd6;
    localparam logic [TGT_W-1:0] TGT_BC = 4'd7;
    localparam logic [TGT_W-1:0] TGT_DE = 4'd8;
    localparam logic [TGT_W-1:0] TGT_HL = 4'd9;

    // Register file rows: A sits alone in the low byte of its row.
    typedef logic [ROW_W-1:0] row_t;
    localparam row_t ROW_A  = 2'd0;
    localparam row_t ROW_BC = 2'd1;
    localparam row_t ROW_DE = 2'd2;
    localparam row_t ROW_HL = 2'd3;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic              en;
        row_t              row;
        logic [WORD_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        flags_t            flags;
        logic              wrote;
        wr_req_t           wr;
    } exec_res_t;

    function automatic row_t tgt_row(input logic [TGT_W-1:0] code);
        row_t r;
        unique case (code)
            TGT_B, TGT_C, TGT_BC: r = ROW_BC;
            TGT_D, TGT_E, TGT_DE: r = ROW_DE;
            TGT_H, TGT_L, TGT_HL: r = ROW_HL;
            default:              r = ROW_A;
        endcase
        return r;
    endfunction

    function automatic logic tgt_hi(input logic [TGT_W-1:0] code);
        return (code == TGT_B) || (code == TGT_D) || (code == TGT_H);
    endfunction

    function automatic logic acc_only(input logic [ACT_W-1:0] act);
        return (act >= ACT_CCF) && (act <= ACT_CPL);
    endfunction

endpackage

// ===== hdl/eight_bit_cpu_alu_with_flags_core.sv =====
// Top level of the 8-bit CPU register file and ALU with Z/N/H/C flags.
// This block holds A, B, C, D, E, H, L and the Z/N/H/C flags and executes one ALU
// operation per input transfer, returning the written (or compared) value and the
// flags after the operation as one output transfer. It sustains one transfer per
// cycle while m_tready does not stall the output; each item passes the register
// file read (a synchronous memory with registered read ports) and then the
// execute stage, whose result is held in the output register. Write
// back from the execute stage is forwarded to a read issued in the same cycle, so
// back-to-back dependent operations see each other's results. The register file
// starts out as zero after reset with no clearing pass: each row has a valid bit.
module eight_bit_cpu_alu_with_flags_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] action, [8:5] target_reg, [11:9] bit_position, [19:12] load_value
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] result_value, [16] flag_zero, [17] flag_subtract, [18] flag_half,
    // [19] flag_carry, [20] wrote_register
    output logic [23:0] m_tdata
);
    import ebc_alu_pkg::*;

    `include "eight_bit_cpu_alu_with_flags_core_assert.svh"

    logic [ACT_W-1:0]  in_act;
    logic [TGT_W-1:0]  in_code;
    logic              s_xfer, s1_adv;

    logic              s1_valid_reg;
    logic [ACT_W-1:0]  s1_act_reg;
    logic [TGT_W-1:0]  s1_code_reg;
    logic [BPOS_W-1:0] s1_bpos_reg;
    logic [BYTE_W-1:0] s1_imm_reg;

    flags_t            flags_reg;
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;

    row_t              rd1_row, rd2_row;
    logic [WORD_W-1:0] rd1_data, rd2_data;
    wr_req_t           wr;
    exec_res_t         ex;

    assign in_act  = s_tdata[4:0];
    assign in_code = s_tdata[8:5];

    // The execute stage hands its item on whenever the output register is free or draining.
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_xfer   = s_tvalid && s_tready;

    // Port 1 reads the operand row, port 2 the accumulator row (HL for the 16-bit add).
    assign rd1_row = acc_only(in_act) ? ROW_A : tgt_row(in_code);
    assign rd2_row = (in_act == ACT_ADDHL) ? ROW_HL : ROW_A;

    ebc_alu_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_xfer),
        .rd1_row  (rd1_row),
        .rd2_row  (rd2_row),
        .wr       (wr),
        .rd1_data (rd1_data),
        .rd2_data (rd2_data)
    );

    ebc_alu_exec u_exec (
        .act  (s1_act_reg),
        .code (s1_code_reg),
        .bpos (s1_bpos_reg),
        .imm  (s1_imm_reg),
        .p1   (rd1_data),
        .p2   (rd2_data),
        .f    (flags_reg),
        .res  (ex)
    );

    // Write back exactly once, when the item leaves the execute stage.
    always_comb begin
        wr    = ex.wr;
        wr.en = ex.wr.en && s1_adv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            flags_reg    <= '0;
        end else begin
            if (s_xfer) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
                flags_reg   <= ex.flags;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_act_reg  <= in_act;
            s1_code_reg <= in_code;
            s1_bpos_reg <= s_tdata[11:9];
            s1_imm_reg  <= s_tdata[19:12];
        end
        if (s1_adv) begin
            m_data_reg <= {3'b000, ex.wrote, ex.flags.c, ex.flags.h, ex.flags.n, ex.flags.z,
                           ex.value};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Flags only move when an item completes execution.
    `EBC_ASSERT_NEXT(a_flags_hold, !s1_adv, $stable(flags_reg), "flags changed without an item")
    // A completing item always lands in the output register.
    `EBC_ASSERT_NEXT(a_out_fill, s1_adv, m_valid_reg, "executed item not presented")
    // The accumulator row never carries anything in its upper byte.
    `EBC_ASSERT_NOW(a_row_a_high, wr.en && (wr.row == ROW_A), wr.data[15:8] == 8'h00,
        "upper byte written in accumulator row")
    // A write back is never issued without an item in the execute stage.
    `EBC_ASSERT_NOW(a_wr_has_item, wr.en, s1_valid_reg && ex.wrote, "stray register write")

endmodule

// ===== hdl/ebc_alu_regfile.sv =====
// Register file memory: four 16-bit rows, two registered read ports, write forwarding.
module ebc_alu_regfile (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  ebc_alu_pkg::row_t             rd1_row,
    input  ebc_alu_pkg::row_t             rd2_row,
    input  ebc_alu_pkg::wr_req_t          wr,
    output logic [ebc_alu_pkg::WORD_W-1:0] rd1_data,
    output logic [ebc_alu_pkg::WORD_W-1:0] rd2_data
);
    import ebc_alu_pkg::*;

    logic [WORD_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   row_valid_reg;
    logic [WORD_W-1:0] rd1_raw_reg, rd2_raw_reg, fwd_data_reg;
    logic              rd1_vld_reg, rd2_vld_reg, rd1_fwd_reg, rd2_fwd_reg;

    // Rows never written since reset read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (wr.en) begin
            row_valid_reg[wr.row] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.row] <= wr.data;
        end
        if (rd_en) begin
            rd1_raw_reg  <= mem[rd1_row];
            rd2_raw_reg  <= mem[rd2_row];
            rd1_vld_reg  <= row_valid_reg[rd1_row];
            rd2_vld_reg  <= row_valid_reg[rd2_row];
            // A write landing on the row being read wins over the stale read.
            rd1_fwd_reg  <= wr.en && (wr.row == rd1_row);
            rd2_fwd_reg  <= wr.en && (wr.row == rd2_row);
            fwd_data_reg <= wr.data;
        end
    end

    assign rd1_data = rd1_fwd_reg ? fwd_data_reg : (rd1_vld_reg ? rd1_raw_reg : '0);
    assign rd2_data = rd2_fwd_reg ? fwd_data_reg : (rd2_vld_reg ? rd2_raw_reg : '0);

endmodule

// ===== hdl/ebc_alu_exec.sv =====
// ALU datapath: computes result, new flags and the register file write-back.
module ebc_alu_exec (
    input  logic [ebc_alu_pkg::ACT_W-1:0]  act,
    input  logic [ebc_alu_pkg::TGT_W-1:0]  code,
    input  logic [ebc_alu_pkg::BPOS_W-1:0] bpos,
    input  logic [ebc_alu_pkg::BYTE_W-1:0] imm,
    input  logic [ebc_alu_pkg::WORD_W-1:0] p1,
    input  logic [ebc_alu_pkg::WORD_W-1:0] p2,
    input  ebc_alu_pkg::flags_t            f,
    output ebc_alu_pkg::exec_res_t         res
);
    import ebc_alu_pkg::*;

    logic              ok, hi, cin, wr_a, wr_t, is_hl;
    logic [BYTE_W-1:0] a, v, r8, bmask;
    logic [WORD_W-1:0] op16, r16;
    logic [BYTE_W:0]   sum9, dif9;
    logic [4:0]        hsum, hdif;
    logic [WORD_W:0]   s17;
    logic [12:0]       h13;
    flags_t            fn;

    always_comb begin
        ok    = (act <= ACT_LDI) && (acc_only(act) || (code <= TGT_HL));
        hi    = tgt_hi(code);
        cin   = f.c;
        v     = hi ? p1[WORD_W-1:BYTE_W] : p1[BYTE_W-1:0];
        a     = p2[BYTE_W-1:0];
        bmask = BYTE_W'(1) << bpos;
        is_hl = act == ACT_ADDHL;

        sum9 = {1'b0, a} + {1'b0, v} + {8'h00, cin && (act == ACT_ADC)};
        hsum = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, cin && (act == ACT_ADC)};
        dif9 = {1'b0, a} - {1'b0, v} - {8'h00, cin && (act == ACT_SBC)};
        hdif = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, cin && (act == ACT_SBC)};

        // 16-bit add to HL: register pairs add whole, single registers zero-extended.
        op16 = (code >= TGT_BC) ? p1 : {8'h00, v};
        s17  = {1'b0, p2} + {1'b0, op16};
        h13  = {1'b0, p2[11:0]} + {1'b0, op16[11:0]};

        r8   = '0;
        r16  = '0;
        fn   = f;
        wr_a = 1'b0;
        wr_t = 1'b0;
        unique case (act)
            ACT_ADD, ACT_ADC: begin
                r8 = sum9[BYTE_W-1:0];
                fn = '{z: r8 == '0, n: 1'b0, h: hsum[4], c: sum9[BYTE_W]};
                wr_a = 1'b1;
            end
            ACT_ADDHL: begin
                r16 = s17[WORD_W-1:0];
                fn = '{z: f.z, n: 1'b0, h: h13[12], c: s17[WORD_W]};
            end
            ACT_SUB, ACT_SBC, ACT_CP: begin
                r8 = dif9[BYTE_W-1:0];
                fn = '{z: r8 == '0, n: 1'b1, h: hdif[4], c: dif9[BYTE_W]};
                wr_a = act != ACT_CP;
            end
            ACT_AND: begin
                r8 = a & v;
                fn = '{z: r8 == '0, n: 1'b0, h: 1'b1, c: 1'b0};
                wr_a = 1'b1;
            end
            ACT_OR, ACT_XOR: begin
                r8 = (act == ACT_OR) ? (a | v) : (a ^ v);
                fn = '{z: r8 == '0, n: 1'b0, h: 1'b0, c: 1'b0};
                wr_a = 1'b1;
            end
            ACT_INC: begin
                r8 = v + 8'd1;
                fn = '{z: r8 == '0, n: 1'b0, h: v[3:0] == 4'hF, c: f.c};
                wr_t = 1'b1;
            end
            ACT_DEC: begin
                r8 = v - 8'd1;
                fn = '{z: r8 == '0, n: 1'b1, h: v[3:0] == 4'h0, c: f.c};
                wr_t = 1'b1;
            end
            ACT_CCF: fn = '{z: f.z, n: 1'b0, h: 1'b0, c: !f.c};
            ACT_SCF: fn = '{z: f.z, n: 1'b0, h: 1'b0, c: 1'b1};
            ACT_RRA, ACT_RRCA: begin
                r8 = {(act == ACT_RRA) ? cin : a[0], a[BYTE_W-1:1]};
                fn = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
                wr_a = 1'b1;
            end
            ACT_RLA, ACT_RLCA: begin
                r8 = {a[BYTE_W-2:0], (act == ACT_RLA) ? cin : a[BYTE_W-1]};
                fn = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[BYTE_W-1]};
                wr_a = 1'b1;
            end
            ACT_CPL: begin
                r8 = ~a;
                fn = '{z: f.z, n: 1'b1, h: 1'b1, c: f.c};
                wr_a = 1'b1;
            end
            ACT_BIT: begin
                r8 = v;
                fn = '{z: (v & bmask) == '0, n: 1'b0, h: 1'b1, c: f.c};
            end
            ACT_RES: begin
                r8 = v & ~bmask;
                wr_t = 1'b1;
            end
            ACT_SET: begin
                r8 = v | bmask;
                wr_t = 1'b1;
            end
            ACT_LDI: begin
                r8 = imm;
                wr_t = 1'b1;
            end
            ACT_SRL, ACT_RR, ACT_RRC, ACT_SRA: begin
                unique case (act)
                    ACT_SRL: r8 = {1'b0, v[BYTE_W-1:1]};
                    ACT_RR:  r8 = {cin, v[BYTE_W-1:1]};
                    ACT_RRC: r8 = {v[0], v[BYTE_W-1:1]};
                    default: r8 = {v[BYTE_W-1], v[BYTE_W-1:1]};
                endcase
                fn = '{z: r8 == '0, n: 1'b0, h: 1'b0, c: v[0]};
                wr_t = 1'b1;
            end
            ACT_RL, ACT_RLC, ACT_SLA: begin
                unique case (act)
                    ACT_RL:  r8 = {v[BYTE_W-2:0], cin};
                    ACT_RLC: r8 = {v[BYTE_W-2:0], v[BYTE_W-1]};
                    default: r8 = {v[BYTE_W-2:0], 1'b0};
                endcase
                fn = '{z: r8 == '0, n: 1'b0, h: 1'b0, c: v[BYTE_W-1]};
                wr_t = 1'b1;
            end
            ACT_SWAP: begin
                r8 = {v[3:0], v[BYTE_W-1:4]};
                fn = '{z: r8 == '0, n: 1'b0, h: 1'b0, c: 1'b0};
                wr_t = 1'b1;
            end
            default: fn = f;
        endcase

        if (!is_hl) begin
            r16 = {8'h00, r8};
        end

        res.value   = ok ? r16 : '0;
        res.flags   = ok ? fn : f;
        res.wrote   = ok && (wr_a || wr_t || is_hl);
        res.wr.en   = res.wrote;
        if (is_hl) begin
            res.wr.row  = ROW_HL;
            res.wr.data = r16;
        end else if (wr_a) begin
            res.wr.row  = ROW_A;
            res.wr.data = {8'h00, r8};
        end else begin
            // Byte write into a pair row keeps the other half as it was read.
            res.wr.row  = tgt_row(code);
            res.wr.data = hi ? {r8, p1[BYTE_W-1:0]} : {p1[WORD_W-1:BYTE_W], r8};
        end
    end

endmodule
